### hw/rtl/msi_va_pkg.sv
// ----------------------------------------------------------------------------
// MSI vector allocator package
// Shared types and fixed constants of the MSI vector allocator.
// ----------------------------------------------------------------------------
package msi_va_pkg;

    // Vector map entries handled per cycle, and the index bits of one entry
    // within that group.
    localparam int DIGIT   = 4;
    localparam int DIGIT_W = 2;

    // Field widths fixed by the message format.
    localparam int OWNER_W = 8;
    localparam int COUNT_W = 8;
    localparam int ADDR_W  = 32;
    localparam int DATA_W  = 16;
    localparam int TRIG_W  = 2;

    // Fixed top address bits of an MSI message.
    localparam logic [11:0] MSI_ADDR_TOP = 12'hFFE;

    // Saturation limit of the freed vector count.
    localparam logic [COUNT_W-1:0] FREED_MAX = 8'hFF;

    // Input command codes.
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // One dynamic vector: its used flag and the owner that holds it.
    typedef struct packed {
        logic               used;
        logic [OWNER_W-1:0] owner;
    } entry_t;

    // Pass control from the sequencer to the digit unit.
    typedef struct packed {
        logic clear;
        logic scan;
        logic mark;
        logic rel;
    } digit_ctl_t;

endpackage

### hw/rtl/msi_vector_allocator_unit.sv
// ----------------------------------------------------------------------------
// MSI vector allocator
// First-fit allocator of contiguous MSI interrupt vectors with per-vector
// owners, plus release of all vectors held by one owner.
//
//   Channel  Direction  tdata (low bit up)                          tuser
//   s_       in         owner_id, vector_count, address_in,          command
//                       data_in, trigger
//   m_       out        first_vector, msg_address, msg_data,         status
//                       freed_count
//
// The dynamic vectors sit in a rotating ring that presents four entries a
// cycle while a pass runs, so one pass covers G = ceil((TOTAL - FIRST) / 4)
// groups (52 by default). An allocate takes a scan pass and, when a run is
// found, a marking pass; a free takes one release pass.
// Reset restores the map at once: dynamic vectors free, padding used, all owners zero.
// A new item is taken while the previous result still waits on m_.
// ----------------------------------------------------------------------------
module msi_vector_allocator_unit #(
    parameter int TOTAL_VECTORS        = 256,
    parameter int FIRST_DYNAMIC_VECTOR = 48
) (
    input  logic        aclk,
    input  logic        aresetn,
    // owner_id, vector_count, address_in, data_in, trigger, zero fill
    input  logic [71:0] s_tdata,
    // command
    input  logic [0:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_vector, msg_address, msg_data, freed_count
    output logic [63:0] m_tdata,
    // status
    output logic [0:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready
);
    import msi_va_pkg::*;

    localparam int DYN_VECTORS = TOTAL_VECTORS - FIRST_DYNAMIC_VECTOR;
    localparam int GROUPS      = (DYN_VECTORS + DIGIT - 1) / DIGIT;
    localparam int DYN_PAD     = GROUPS * DIGIT;
    localparam int GRP_W       = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int POS_W       = $clog2(DYN_PAD + 1);
    localparam int SUM_W       = $clog2(TOTAL_VECTORS + DIGIT) + 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_MARK = 5'b00100,
        ST_FREE = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [GRP_W-1:0]   pos_reg, pos_next;
    logic               cmd_reg;
    logic [OWNER_W-1:0] owner_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [TRIG_W-1:0]  trig_reg;

    logic        m_valid_reg;
    logic [63:0] m_data_reg;
    logic        m_status_reg;

    digit_ctl_t                ctl;
    logic                      shift_en;
    logic                      last_grp;
    logic                      load_out;
    entry_t [DIGIT-1:0]        head_digit;
    entry_t [DIGIT-1:0]        tail_digit;
    logic                      found;
    logic [POS_W-1:0]          start_pos;
    logic [COUNT_W-1:0]        freed;
    logic [SUM_W-1:0]          vec_sum;
    logic [7:0]                first_vec;
    logic [ADDR_W-1:0]         msg_addr;
    logic [DATA_W-1:0]         msg_data;

    msi_va_ring #(
        .DYN_VECTORS (DYN_VECTORS),
        .DEPTH       (DYN_PAD)
    ) u_ring (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (shift_en),
        .tail_digit (tail_digit),
        .head_digit (head_digit)
    );

    msi_va_digit #(
        .GRP_W (GRP_W),
        .POS_W (POS_W)
    ) u_digit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .pos        (pos_reg),
        .owner      (owner_reg),
        .count      (count_reg),
        .head_digit (head_digit),
        .tail_digit (tail_digit),
        .found      (found),
        .start_pos  (start_pos),
        .freed      (freed)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign last_grp = (pos_reg == GRP_W'(GROUPS - 1));
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Pass sequencer: scan, optional mark, or free, then hand off the result.
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        shift_en   = 1'b0;
        ctl        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctl.clear  = 1'b1;
                    pos_next   = '0;
                    state_next = (s_tuser[0] == CMD_FREE) ? ST_FREE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                shift_en = 1'b1;
                ctl.scan = 1'b1;
                pos_next = last_grp ? '0 : pos_reg + GRP_W'(1);
                if (last_grp) begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                if (!found) begin
                    state_next = ST_DONE;
                end else begin
                    shift_en = 1'b1;
                    ctl.mark = 1'b1;
                    pos_next = last_grp ? '0 : pos_reg + GRP_W'(1);
                    if (last_grp) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_FREE: begin
                shift_en = 1'b1;
                ctl.rel  = 1'b1;
                pos_next = last_grp ? '0 : pos_reg + GRP_W'(1);
                if (last_grp) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Capture the fields of an accepted item.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg   <= s_tuser[0];
            owner_reg <= s_tdata[7:0];
            count_reg <= s_tdata[15:8];
            addr_reg  <= s_tdata[47:16];
            data_reg  <= s_tdata[63:48];
            trig_reg  <= s_tdata[65:64];
        end
    end

    // Compose the MSI message from the found run.
    assign vec_sum   = SUM_W'(FIRST_DYNAMIC_VECTOR) + SUM_W'(start_pos);
    assign first_vec = vec_sum[7:0];
    assign msg_addr  = {MSI_ADDR_TOP, addr_reg[19:0]};
    assign msg_data  = {trig_reg, data_reg[13:11], 3'b000, first_vec};

    // Output register: holds a finished result until the sink takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (cmd_reg == CMD_FREE) begin
                m_status_reg <= STATUS_OK;
                m_data_reg   <= {freed, 56'd0};
            end else if (found) begin
                m_status_reg <= STATUS_OK;
                m_data_reg   <= {8'd0, msg_data, msg_addr, first_vec};
            end else begin
                m_status_reg <= STATUS_FAIL;
                m_data_reg   <= '0;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_status_reg;

endmodule

### hw/rtl/msi_va_ring.sv
// ----------------------------------------------------------------------------
// MSI vector allocator ring store
// Circular shift line holding the used flag and owner of every dynamic
// vector, rotated by one group of entries per cycle while shift_en is high.
// ----------------------------------------------------------------------------
module msi_va_ring #(
    parameter int DYN_VECTORS = 208,
    parameter int DEPTH       = 208
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  logic                                       shift_en,
    input  msi_va_pkg::entry_t [msi_va_pkg::DIGIT-1:0] tail_digit,
    output msi_va_pkg::entry_t [msi_va_pkg::DIGIT-1:0] head_digit
);
    import msi_va_pkg::*;

    entry_t ring_reg [DEPTH];

    // Rotate the ring; the processed head group re-enters at the tail.
    // Padding entries past the last vector stay used forever.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DEPTH; j++) begin
                ring_reg[j].used  <= (j >= DYN_VECTORS);
                ring_reg[j].owner <= '0;
            end
        end else if (shift_en) begin
            for (int j = 0; j < DEPTH - DIGIT; j++) begin
                ring_reg[j] <= ring_reg[j + DIGIT];
            end
            for (int k = 0; k < DIGIT; k++) begin
                ring_reg[DEPTH - DIGIT + k] <= tail_digit[k];
            end
        end
    end

    // The head group is the one under work in this cycle.
    always_comb begin
        for (int k = 0; k < DIGIT; k++) begin
            head_digit[k] = ring_reg[k];
        end
    end

endmodule

### hw/rtl/msi_va_digit.sv
// ----------------------------------------------------------------------------
// MSI vector allocator digit unit
// Works on one group of ring entries per cycle: tracks the free run during
// a scan, marks the found run, and releases the entries of an owner.
// ----------------------------------------------------------------------------
module msi_va_digit #(
    parameter int GRP_W = 6,
    parameter int POS_W = 8
) (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  msi_va_pkg::digit_ctl_t                     ctl,
    input  logic [GRP_W-1:0]                           pos,
    input  logic [msi_va_pkg::OWNER_W-1:0]             owner,
    input  logic [msi_va_pkg::COUNT_W-1:0]             count,
    input  msi_va_pkg::entry_t [msi_va_pkg::DIGIT-1:0] head_digit,
    output msi_va_pkg::entry_t [msi_va_pkg::DIGIT-1:0] tail_digit,
    output logic                                       found,
    output logic [POS_W-1:0]                           start_pos,
    output logic [msi_va_pkg::COUNT_W-1:0]             freed
);
    import msi_va_pkg::*;

    logic [COUNT_W-1:0] run_reg, run_next;
    logic               found_reg, found_next;
    logic [POS_W-1:0]   start_reg, start_next;
    logic [POS_W-1:0]   end_reg, end_next;
    logic [COUNT_W-1:0] freed_reg, freed_next;

    // Per-entry work on the head group, lowest entry first.
    always_comb begin
        run_next   = run_reg;
        found_next = found_reg;
        start_next = start_reg;
        end_next   = end_reg;
        freed_next = freed_reg;
        tail_digit = head_digit;
        for (int k = 0; k < DIGIT; k++) begin
            logic [POS_W-1:0] idx;
            idx = POS_W'({pos, DIGIT_W'(k)});
            // First-fit scan: stop tracking once the run is found.
            if (ctl.scan && !found_next) begin
                if (head_digit[k].used) begin
                    run_next = '0;
                end else begin
                    run_next = run_next + COUNT_W'(1);
                    if (count != '0 && run_next == count) begin
                        found_next = 1'b1;
                        end_next   = idx + POS_W'(1);
                        start_next = idx + POS_W'(1) - POS_W'(count);
                    end
                end
            end
            // Claim every entry of the found run for the owner.
            if (ctl.mark && idx >= start_reg && idx < end_reg) begin
                tail_digit[k].used  = 1'b1;
                tail_digit[k].owner = owner;
            end
            // Release the entries of a nonzero owner and count them.
            if (ctl.rel && owner != '0 && head_digit[k].owner == owner) begin
                tail_digit[k].used  = 1'b0;
                tail_digit[k].owner = '0;
                if (freed_next != FREED_MAX) begin
                    freed_next = freed_next + COUNT_W'(1);
                end
            end
        end
        if (ctl.clear) begin
            run_next   = '0;
            found_next = 1'b0;
            freed_next = '0;
        end
    end

    // Accumulators of the current item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= '0;
            found_reg <= 1'b0;
            freed_reg <= '0;
            start_reg <= '0;
            end_reg   <= '0;
        end else begin
            run_reg   <= run_next;
            found_reg <= found_next;
            freed_reg <= freed_next;
            start_reg <= start_next;
            end_reg   <= end_next;
        end
    end

    assign found     = found_reg;
    assign start_pos = start_reg;
    assign freed     = freed_reg;

endmodule
